@@ rtl/sdcis_pkg.sv @@
// Shared types, codes and lookup tables for the SD card bring-up sequencer.
package sdcis_pkg;

  // Transaction codes on the input channel
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_RESP  = 2'd1;
  localparam logic [1:0] CMD_XFER  = 2'd2;

  // Response status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_TMO = 2'd1;

  // Result actions
  localparam logic [2:0] ACT_SEND  = 3'd0;
  localparam logic [2:0] ACT_POWER = 3'd1;
  localparam logic [2:0] ACT_CLOCK = 3'd2;
  localparam logic [2:0] ACT_BUS4  = 3'd3;
  localparam logic [2:0] ACT_DONE  = 3'd4;
  localparam logic [2:0] ACT_FAIL  = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_IO    = 2'd1;
  localparam logic [1:0] ERR_UNUSE = 2'd2;
  localparam logic [1:0] ERR_TMO   = 2'd3;

  // Expected response kinds
  localparam logic [1:0] RK_NONE  = 2'd0;
  localparam logic [1:0] RK_SHORT = 2'd1;
  localparam logic [1:0] RK_NOCRC = 2'd2;
  localparam logic [1:0] RK_LONG  = 2'd3;

  // SD command indexes
  localparam logic [5:0] SD_CMD0  = 6'd0;
  localparam logic [5:0] SD_CMD2  = 6'd2;
  localparam logic [5:0] SD_CMD3  = 6'd3;
  localparam logic [5:0] SD_ACMD6 = 6'd6;
  localparam logic [5:0] SD_CMD7  = 6'd7;
  localparam logic [5:0] SD_CMD8  = 6'd8;
  localparam logic [5:0] SD_CMD9  = 6'd9;
  localparam logic [5:0] SD_CMD17 = 6'd17;
  localparam logic [5:0] SD_CMD24 = 6'd24;
  localparam logic [5:0] SD_ACMD41 = 6'd41;
  localparam logic [5:0] SD_CMD55 = 6'd55;

  // Command arguments and response checks
  localparam logic [31:0] ARG_CMD8    = 32'h0000_01AA;
  localparam logic [11:0] CMD8_ECHO   = 12'h1AA;
  localparam logic [31:0] ARG_ACMD41  = 32'h40FF_8000;
  localparam logic [31:0] ARG_BUS4    = 32'h0000_0002;
  localparam logic [15:0] RETRY_RESET = 16'd10000;

  typedef enum logic [12:0] {
    PH_IDLE   = 13'b0_0000_0000_0001,
    PH_CMD0   = 13'b0_0000_0000_0010,
    PH_CMD8   = 13'b0_0000_0000_0100,
    PH_C55A   = 13'b0_0000_0000_1000,
    PH_ACMD41 = 13'b0_0000_0001_0000,
    PH_CMD2   = 13'b0_0000_0010_0000,
    PH_CMD3   = 13'b0_0000_0100_0000,
    PH_CMD9   = 13'b0_0000_1000_0000,
    PH_CMD7   = 13'b0_0001_0000_0000,
    PH_C55B   = 13'b0_0010_0000_0000,
    PH_ACMD6  = 13'b0_0100_0000_0000,
    PH_READY  = 13'b0_1000_0000_0000,
    PH_FAILED = 13'b1_0000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  status;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic [31:0] block_number;
    logic        write_dir;
  } sdcis_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic        data_transfer;
    logic [1:0]  error_code;
    logic        high_capacity;
    logic [15:0] card_address;
    logic [32:0] capacity_blocks;
    logic [29:0] max_clock_hz;
    logic        last;
  } sdcis_out_t;

  // Command part of one result
  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic        data_transfer;
    logic [1:0]  error_code;
  } sdcis_cmd_t;

  function automatic sdcis_cmd_t mk_send(logic [5:0] idx, logic [31:0] arg, logic [1:0] rk);
    sdcis_cmd_t c;
    c               = '0;
    c.action        = ACT_SEND;
    c.cmd_index     = idx;
    c.cmd_arg       = arg;
    c.resp_kind     = rk;
    return c;
  endfunction

  function automatic sdcis_cmd_t mk_act(logic [2:0] act, logic [1:0] err);
    sdcis_cmd_t c;
    c            = '0;
    c.action     = act;
    c.error_code = err;
    return c;
  endfunction

  // Transfer-rate unit divided by ten; reserved units decode to zero
  function automatic logic [23:0] freq_unit_div10(logic [2:0] code);
    logic [23:0] v;
    unique case (code)
      3'd0:    v = 24'd10000;
      3'd1:    v = 24'd100000;
      3'd2:    v = 24'd1000000;
      3'd3:    v = 24'd10000000;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // Transfer-rate time value times ten
  function automatic logic [6:0] freq_mult_x10(logic [3:0] code);
    logic [6:0] v;
    unique case (code)
      4'd0:    v = 7'd0;
      4'd1:    v = 7'd10;
      4'd2:    v = 7'd12;
      4'd3:    v = 7'd13;
      4'd4:    v = 7'd15;
      4'd5:    v = 7'd20;
      4'd6:    v = 7'd25;
      4'd7:    v = 7'd30;
      4'd8:    v = 7'd35;
      4'd9:    v = 7'd40;
      4'd10:   v = 7'd45;
      4'd11:   v = 7'd50;
      4'd12:   v = 7'd55;
      4'd13:   v = 7'd60;
      4'd14:   v = 7'd70;
      default: v = 7'd80;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/sdcis_outq.sv @@
// Result queue: shifting register FIFO that takes up to two results per cycle.
module sdcis_outq #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            push_cnt,
  input  sdcis_pkg::sdcis_out_t push0,
  input  sdcis_pkg::sdcis_out_t push1,
  output logic                  no_room,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sdcis_pkg::sdcis_out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  sdcis_pkg::sdcis_out_t slot_r   [DEPTH];
  sdcis_pkg::sdcis_out_t slot_nxt [DEPTH];
  logic [CW-1:0]         cnt_r, cnt_nxt, base_cnt;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[0];
  assign pop       = out_valid && !out_stall;
  // Need two free slots before taking a new transaction
  assign no_room   = (cnt_r > CW'(DEPTH - 2));

  assign base_cnt = cnt_r - CW'(pop);
  assign cnt_nxt  = base_cnt + CW'(push_cnt);

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    sdcis_pkg::sdcis_out_t shifted;
    if (i < DEPTH - 1) begin : g_mid
      assign shifted = pop ? slot_r[i+1] : slot_r[i];
    end else begin : g_end
      assign shifted = slot_r[i];
    end
    always_comb begin
      slot_nxt[i] = shifted;
      if (push_cnt != 2'd0 && base_cnt == CW'(i)) begin
        slot_nxt[i] = push0;
      end
      if (push_cnt == 2'd2 && (base_cnt + CW'(1)) == CW'(i)) begin
        slot_nxt[i] = push1;
      end
    end
    always_ff @(posedge clk) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/sd_card_init_sequencer.sv @@
// Top level of the host-side SD card bring-up sequencer.
// Each input transaction is decoded in the cycle it is accepted: a start
// transaction powers the card and issues CMD0, each response transaction moves
// the sequence CMD8, CMD55/ACMD41 polling, CMD2, CMD3, CMD9 (clock raise), CMD7,
// CMD55/ACMD6 to done, and a transfer transaction in the ready phase yields a
// CMD17 or CMD24. A transaction produces zero, one or two result transactions,
// which go into a small result queue so the input side keeps moving while the
// consumer stalls. An input is taken every cycle while the queue has two free slots;
// results leave at one per cycle while out_stall is low, so two-result items can stall
// the input. The user must write the retry_limit register (retry_r) through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce it.
module sd_card_init_sequencer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sdcis_pkg::sdcis_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sdcis_pkg::sdcis_out_t out_data
);

  sdcis_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]       retry_r;
  logic [15:0]       poll_r, poll_nxt, poll_inc;
  logic              sdhc_r, sdhc_nxt;
  logic [15:0]       rca_r, rca_nxt;
  logic [32:0]       cap_r, cap_nxt;
  logic [29:0]       clk_r, clk_nxt;

  logic                  accept;
  logic [1:0]            n_res;
  sdcis_pkg::sdcis_cmd_t c0, c1;
  sdcis_pkg::sdcis_out_t r0, r1;
  logic                  resp_live;

  // CSD decode
  logic [6:0]  rate_code;
  logic [29:0] clk_prod;
  logic [12:0] v1_size;
  logic [4:0]  v1_shift;
  logic [36:0] v1_bytes_blk;
  logic [22:0] v2_size;
  logic [32:0] csd_cap;

  assign accept = in_valid && !in_stall;

  // Maximum clock: unit/10 times value*10; at most 800 MHz, fits 30 bits
  assign rate_code = in_data.resp_word0[6:0];
  assign clk_prod  = {6'b0, sdcis_pkg::freq_unit_div10(rate_code[2:0])} *
                     {23'b0, sdcis_pkg::freq_mult_x10(rate_code[6:3])};

  // v1: (C_SIZE+1) << (size multiplier + 2 + block length code), then in 512-byte units
  assign v1_size      = {1'b0, in_data.resp_word1[9:0], in_data.resp_word2[31:30]} + 13'd1;
  assign v1_shift     = 5'({2'b0, in_data.resp_word2[17:15]} + 5'd2 +
                           {1'b0, in_data.resp_word1[19:16]});
  assign v1_bytes_blk = {24'b0, v1_size} << v1_shift;
  // v2: (C_SIZE+1) * 1024 blocks
  assign v2_size      = {1'b0, in_data.resp_word1[5:0], in_data.resp_word2[31:16]} + 23'd1;
  assign csd_cap      = sdhc_r ? {v2_size, 10'b0} : {5'b0, v1_bytes_blk[36:9]};

  assign poll_inc  = poll_r + 16'd1;
  assign resp_live = !(phase_r == sdcis_pkg::PH_IDLE || phase_r == sdcis_pkg::PH_READY ||
                       phase_r == sdcis_pkg::PH_FAILED);

  always_comb begin
    phase_nxt = phase_r;
    poll_nxt  = poll_r;
    sdhc_nxt  = sdhc_r;
    rca_nxt   = rca_r;
    cap_nxt   = cap_r;
    clk_nxt   = clk_r;
    n_res     = 2'd0;
    c0        = '0;
    c1        = '0;

    priority if (in_data.command == sdcis_pkg::CMD_START) begin
      // Restart from scratch: power on, then CMD0
      phase_nxt = sdcis_pkg::PH_CMD0;
      poll_nxt  = '0;
      sdhc_nxt  = 1'b0;
      rca_nxt   = '0;
      cap_nxt   = '0;
      clk_nxt   = '0;
      n_res     = 2'd2;
      c0        = sdcis_pkg::mk_act(sdcis_pkg::ACT_POWER, sdcis_pkg::ERR_NONE);
      c1        = sdcis_pkg::mk_send(sdcis_pkg::SD_CMD0, '0, sdcis_pkg::RK_NONE);
    end else if (in_data.command == sdcis_pkg::CMD_XFER) begin
      if (phase_r == sdcis_pkg::PH_READY) begin
        // Block address on high capacity cards, byte address (wrapping) otherwise
        n_res = 2'd1;
        c0 = sdcis_pkg::mk_send(in_data.write_dir ? sdcis_pkg::SD_CMD24 : sdcis_pkg::SD_CMD17,
                                sdhc_r ? in_data.block_number
                                       : {in_data.block_number[22:0], 9'b0},
                                sdcis_pkg::RK_SHORT);
        c0.data_transfer = 1'b1;
      end
    end else if (in_data.command == sdcis_pkg::CMD_RESP && resp_live) begin
      n_res = 2'd1;
      priority if (phase_r == sdcis_pkg::PH_CMD8 &&
                   (in_data.status == sdcis_pkg::ST_TMO ||
                    (in_data.status == sdcis_pkg::ST_OK &&
                     in_data.resp_word0[11:0] != sdcis_pkg::CMD8_ECHO))) begin
        // No or wrong voltage echo: card cannot be used
        phase_nxt = sdcis_pkg::PH_FAILED;
        c0 = sdcis_pkg::mk_act(sdcis_pkg::ACT_FAIL, sdcis_pkg::ERR_UNUSE);
      end else if (in_data.status != sdcis_pkg::ST_OK) begin
        phase_nxt = sdcis_pkg::PH_FAILED;
        c0 = sdcis_pkg::mk_act(sdcis_pkg::ACT_FAIL, sdcis_pkg::ERR_IO);
      end else begin
        unique case (phase_r)
          sdcis_pkg::PH_CMD0: begin
            phase_nxt = sdcis_pkg::PH_CMD8;
            c0 = sdcis_pkg::mk_send(sdcis_pkg::SD_CMD8, sdcis_pkg::ARG_CMD8,
                                    sdcis_pkg::RK_SHORT);
          end
          sdcis_pkg::PH_CMD8: begin
            poll_nxt  = '0;
            phase_nxt = sdcis_pkg::PH_C55A;
            c0 = sdcis_pkg::mk_send(sdcis_pkg::SD_CMD55, '0, sdcis_pkg::RK_SHORT);
          end
          sdcis_pkg::PH_C55A: begin
            if (!in_data.resp_word0[5]) begin
              // APP_CMD not acknowledged
              phase_nxt = sdcis_pkg::PH_FAILED;
              c0 = sdcis_pkg::mk_act(sdcis_pkg::ACT_FAIL, sdcis_pkg::ERR_IO);
            end else begin
              phase_nxt = sdcis_pkg::PH_ACMD41;
              c0 = sdcis_pkg::mk_send(sdcis_pkg::SD_ACMD41, sdcis_pkg::ARG_ACMD41,
                                      sdcis_pkg::RK_NOCRC);
            end
          end
          sdcis_pkg::PH_ACMD41: begin
            if (in_data.resp_word0[31]) begin
              // Card ready: latch CCS
              sdhc_nxt  = in_data.resp_word0[30];
              phase_nxt = sdcis_pkg::PH_CMD2;
              c0 = sdcis_pkg::mk_send(sdcis_pkg::SD_CMD2, '0, sdcis_pkg::RK_LONG);
            end else begin
              poll_nxt = poll_inc;
              // A zero limit behaves as one poll; wrap to zero also ends polling
              if (poll_inc >= retry_r || poll_inc == '0) begin
                phase_nxt = sdcis_pkg::PH_FAILED;
                c0 = sdcis_pkg::mk_act(sdcis_pkg::ACT_FAIL, sdcis_pkg::ERR_TMO);
              end else begin
                phase_nxt = sdcis_pkg::PH_C55A;
                c0 = sdcis_pkg::mk_send(sdcis_pkg::SD_CMD55, '0, sdcis_pkg::RK_SHORT);
              end
            end
          end
          sdcis_pkg::PH_CMD2: begin
            phase_nxt = sdcis_pkg::PH_CMD3;
            c0 = sdcis_pkg::mk_send(sdcis_pkg::SD_CMD3, '0, sdcis_pkg::RK_SHORT);
          end
          sdcis_pkg::PH_CMD3: begin
            rca_nxt   = in_data.resp_word0[31:16];
            phase_nxt = sdcis_pkg::PH_CMD9;
            c0 = sdcis_pkg::mk_send(sdcis_pkg::SD_CMD9, {in_data.resp_word0[31:16], 16'b0},
                                    sdcis_pkg::RK_LONG);
          end
          sdcis_pkg::PH_CMD9: begin
            // Capture CSD, raise the clock, then select the card
            cap_nxt   = csd_cap;
            clk_nxt   = clk_prod;
            phase_nxt = sdcis_pkg::PH_CMD7;
            n_res     = 2'd2;
            c0 = sdcis_pkg::mk_act(sdcis_pkg::ACT_CLOCK, sdcis_pkg::ERR_NONE);
            c1 = sdcis_pkg::mk_send(sdcis_pkg::SD_CMD7, {rca_r, 16'b0}, sdcis_pkg::RK_SHORT);
          end
          sdcis_pkg::PH_CMD7: begin
            phase_nxt = sdcis_pkg::PH_C55B;
            c0 = sdcis_pkg::mk_send(sdcis_pkg::SD_CMD55, {rca_r, 16'b0}, sdcis_pkg::RK_SHORT);
          end
          sdcis_pkg::PH_C55B: begin
            if (!in_data.resp_word0[5]) begin
              phase_nxt = sdcis_pkg::PH_FAILED;
              c0 = sdcis_pkg::mk_act(sdcis_pkg::ACT_FAIL, sdcis_pkg::ERR_IO);
            end else begin
              phase_nxt = sdcis_pkg::PH_ACMD6;
              c0 = sdcis_pkg::mk_send(sdcis_pkg::SD_ACMD6, sdcis_pkg::ARG_BUS4,
                                      sdcis_pkg::RK_SHORT);
            end
          end
          sdcis_pkg::PH_ACMD6: begin
            phase_nxt = sdcis_pkg::PH_READY;
            n_res     = 2'd2;
            c0 = sdcis_pkg::mk_act(sdcis_pkg::ACT_BUS4, sdcis_pkg::ERR_NONE);
            c1 = sdcis_pkg::mk_act(sdcis_pkg::ACT_DONE, sdcis_pkg::ERR_NONE);
          end
          default: begin
            n_res = 2'd0;
          end
        endcase
      end
    end else begin
      n_res = 2'd0;
    end
  end

  // Attach the card status as it stands after this transaction
  always_comb begin
    r0 = {c0, sdhc_nxt, rca_nxt, cap_nxt, clk_nxt, (n_res == 2'd1)};
    r1 = {c1, sdhc_nxt, rca_nxt, cap_nxt, clk_nxt, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdcis_pkg::PH_IDLE;
      retry_r <= sdcis_pkg::RETRY_RESET;
      poll_r  <= '0;
      sdhc_r  <= 1'b0;
      rca_r   <= '0;
      cap_r   <= '0;
      clk_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        retry_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        poll_r  <= poll_nxt;
        sdhc_r  <= sdhc_nxt;
        rca_r   <= rca_nxt;
        cap_r   <= cap_nxt;
        clk_r   <= clk_nxt;
      end
    end
  end

  sdcis_outq #(
    .DEPTH(QUEUE_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (accept ? n_res : 2'd0),
    .push0    (r0),
    .push1    (r1),
    .no_room  (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
